[hdl/bpc_pkg.sv]
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants of the barometric pressure compensation unit.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned RawTempW = 16;
  localparam int unsigned RawPresW = 19;
  localparam int unsigned TempW    = 16;
  localparam int unsigned PresW    = 20;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned OssW     = 2;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 40;

  // Configuration register indexes
  typedef enum logic [CfgAddrW-1:0] {
    RegAc1Ac2 = 3'd0,
    RegAc3Ac4 = 3'd1,
    RegAc5Ac6 = 3'd2,
    RegB1B2   = 3'd3,
    RegMcMd   = 3'd4,
    RegOss    = 3'd5
  } cfg_reg_e;

  localparam logic [WordW-1:0] TempOffset  = 32'd4000;
  localparam logic [WordW-1:0] B4Bias      = 32'd32768;
  localparam logic [WordW-1:0] B7Scale     = 32'd50000;
  localparam logic [WordW-1:0] PresCoefSq  = 32'd3038;
  localparam logic [WordW-1:0] PresCoefLin = 32'hFFFF_E343;  // -7357
  localparam logic [WordW-1:0] PresOffset  = 32'd3791;
  localparam logic [WordW-1:0] TempRound   = 32'd8;

  localparam logic signed [WordW-1:0] TempMax = 32'sd32767;
  localparam logic signed [WordW-1:0] TempMin = -32'sd32768;
  localparam logic signed [WordW-1:0] PresMax = 32'sd1048575;

endpackage

[hdl/bpc_div_pipe.sv]
// ----------------------------------------------------------------------------
// bpc_div_pipe
// Pipelined unsigned restoring divider, one quotient bit per stage, with a
// sideband that travels alongside each beat.
// ----------------------------------------------------------------------------
module bpc_div_pipe #(
  parameter int unsigned W  = 32,
  parameter int unsigned SW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [W-1:0]  num_i,
  input  logic [W-1:0]  den_i,
  input  logic [SW-1:0] side_i,
  output logic          vld_o,
  output logic [W-1:0]  quo_o,
  output logic [SW-1:0] side_o
);

  logic [W-1:0]  rem_q  [W];
  logic [W-1:0]  num_q  [W];
  logic [W-1:0]  den_q  [W];
  logic [W-1:0]  quo_q  [W];
  logic [SW-1:0] side_q [W];
  logic          vld_q  [W];

  for (genvar s = 0; s < W; s++) begin : g_stage
    logic [W-1:0]  rin;
    logic [W-1:0]  nin;
    logic [W-1:0]  din;
    logic [W-1:0]  qin;
    logic [SW-1:0] sin;
    logic          vin;
    logic [W:0]    trial;

    if (s == 0) begin : g_first
      assign rin = '0;
      assign nin = num_i;
      assign din = den_i;
      assign qin = '0;
      assign sin = side_i;
      assign vin = vld_i;
    end else begin : g_next
      assign rin = rem_q[s-1];
      assign nin = num_q[s-1];
      assign din = den_q[s-1];
      assign qin = quo_q[s-1];
      assign sin = side_q[s-1];
      assign vin = vld_q[s-1];
    end

    // trial subtract; the top bit is the borrow
    assign trial = {rin, nin[W-1]} - {1'b0, din};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!trial[W]) begin
          rem_q[s] <= trial[W-1:0];
        end else begin
          rem_q[s] <= {rin[W-2:0], nin[W-1]};
        end
        quo_q[s]  <= {qin[W-2:0], ~trial[W]};
        num_q[s]  <= {nin[W-2:0], 1'b0};
        den_q[s]  <= din;
        side_q[s] <= sin;
      end
    end
  end

  assign vld_o  = vld_q[W-1];
  assign quo_o  = quo_q[W-1];
  assign side_o = side_q[W-1];

endmodule

[hdl/barometric_pressure_compensation_unit.sv]
// ----------------------------------------------------------------------------
// barometric_pressure_compensation_unit
// Integer temperature and pressure compensation of a barometric sensor.
// ----------------------------------------------------------------------------
// One beat in carries a raw temperature and a raw pressure word; one beat out
// carries the temperature in tenths of a degree (saturated to 16 bits signed),
// the pressure in pascals (saturated to 0..1048575) and a fault flag that is
// set, with both results zero, when either divisor of the formula is zero.
// The unit takes one beat every cycle unless the pipe holds. Its pipe is made
// of the two 32-stage pipelined dividers (temperature term X2 and the
// pressure quotient) plus the multiply and add stages around them. All stages
// share one advance enable: when the output holds an unaccepted beat and the
// sink is not ready, the whole pipe holds. Load the calibration words and the
// oversampling setting while no beat is in flight; cfg_ready_o is always high
// and writes to an index beyond the list are dropped.
// ----------------------------------------------------------------------------
module barometric_pressure_compensation_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bpc_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [bpc_pkg::WordW-1:0]     cfg_data_i,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [15:0] raw_temperature, [34:16] raw_pressure, [39:35] zero
  input  logic [bpc_pkg::InDataW-1:0]   s_axis_tdata,
  // output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [15:0] temperature_tenths, [35:16] pressure_pa, [39:36] zero
  output logic [bpc_pkg::OutDataW-1:0]  m_axis_tdata,
  // [0] divide_fault
  output logic                          m_axis_tuser
);

  import bpc_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [WordW-1:0] cal_ac1_ac2_q, cal_ac3_ac4_q, cal_ac5_ac6_q;
  logic [WordW-1:0] cal_b1_b2_q, cal_mc_md_q;
  logic [OssW-1:0]  oss_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_ac1_ac2_q <= '0;
      cal_ac3_ac4_q <= '0;
      cal_ac5_ac6_q <= '0;
      cal_b1_b2_q   <= '0;
      cal_mc_md_q   <= '0;
      oss_q         <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        RegAc1Ac2: cal_ac1_ac2_q <= cfg_data_i;
        RegAc3Ac4: cal_ac3_ac4_q <= cfg_data_i;
        RegAc5Ac6: cal_ac5_ac6_q <= cfg_data_i;
        RegB1B2:   cal_b1_b2_q   <= cfg_data_i;
        RegMcMd:   cal_mc_md_q   <= cfg_data_i;
        RegOss:    oss_q         <= cfg_data_i[OssW-1:0];
        default: ;  // drop writes beyond the list
      endcase
    end
  end

  // Coefficients widened to 32-bit words (sign or zero extension)
  logic [WordW-1:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;

  assign ac1 = {{16{cal_ac1_ac2_q[31]}}, cal_ac1_ac2_q[31:16]};
  assign ac2 = {{16{cal_ac1_ac2_q[15]}}, cal_ac1_ac2_q[15:0]};
  assign ac3 = {{16{cal_ac3_ac4_q[31]}}, cal_ac3_ac4_q[31:16]};
  assign ac4 = {16'd0, cal_ac3_ac4_q[15:0]};
  assign ac5 = {16'd0, cal_ac5_ac6_q[31:16]};
  assign ac6 = {16'd0, cal_ac5_ac6_q[15:0]};
  assign b1  = {{16{cal_b1_b2_q[31]}}, cal_b1_b2_q[31:16]};
  assign b2  = {{16{cal_b1_b2_q[15]}}, cal_b1_b2_q[15:0]};
  assign mc  = {{16{cal_mc_md_q[31]}}, cal_mc_md_q[31:16]};
  assign md  = {{16{cal_mc_md_q[15]}}, cal_mc_md_q[15:0]};

  // --------------------------------------------------------------------------
  // Pipeline advance: hold every stage while the output beat waits
  // --------------------------------------------------------------------------
  logic en;
  logic out_vld_q;

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  logic [WordW-1:0]    ut;
  assign ut = {16'd0, s_axis_tdata[RawTempW-1:0]};

  // Stage A: (UT - AC6) * AC5
  logic             a_vld_q;
  logic [WordW-1:0] a_prod_q;
  logic [RawPresW-1:0] a_up_q;

  // Stage B: X1, divider operands for X2 = (MC << 11) / (X1 + MD)
  logic             b_vld_q;
  logic [WordW-1:0] b_x1_q, b_num_q, b_den_q;
  logic             b_neg_q, b_ft_q;
  logic [RawPresW-1:0] b_up_q;

  logic [WordW-1:0] b_x1_d, b_tmp_d, b_mcs_d;
  assign b_x1_d  = WordW'($signed(a_prod_q) >>> 15);
  assign b_tmp_d = b_x1_d + md;
  assign b_mcs_d = mc << 11;

  // Temperature divider
  localparam int unsigned TSideW = WordW + 2 + RawPresW;
  logic               td_vld;
  logic [WordW-1:0]   td_quo;
  logic [TSideW-1:0]  td_side;

  bpc_div_pipe #(
    .W  (WordW),
    .SW (TSideW)
  ) u_div_temp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (b_vld_q),
    .num_i  (b_num_q),
    .den_i  (b_den_q),
    .side_i ({b_x1_q, b_neg_q, b_ft_q, b_up_q}),
    .vld_o  (td_vld),
    .quo_o  (td_quo),
    .side_o (td_side)
  );

  // Stage C: sign the quotient
  logic             c_vld_q, c_ft_q;
  logic [WordW-1:0] c_x1_q, c_x2_q;
  logic [RawPresW-1:0] c_up_q;

  // Stage D: B5
  logic             d_vld_q, d_ft_q;
  logic [WordW-1:0] d_b5_q;
  logic [RawPresW-1:0] d_up_q;

  // Stage E: B6 and the saturated temperature
  logic             e_vld_q, e_ft_q;
  logic [WordW-1:0] e_b6_q;
  logic [TempW-1:0] e_t_q;
  logic [RawPresW-1:0] e_up_q;

  logic signed [WordW-1:0] e_t_d;
  logic [TempW-1:0]        e_tsat_d;
  assign e_t_d = $signed(d_b5_q + TempRound) >>> 4;
  always_comb begin
    if (e_t_d > TempMax) begin
      e_tsat_d = TempMax[TempW-1:0];
    end else if (e_t_d < TempMin) begin
      e_tsat_d = TempMin[TempW-1:0];
    end else begin
      e_tsat_d = e_t_d[TempW-1:0];
    end
  end

  // Stage F: products on B6
  logic             f_vld_q, f_ft_q;
  logic [WordW-1:0] f_sq_q, f_ac2_q, f_ac3_q;
  logic [TempW-1:0] f_t_q;
  logic [RawPresW-1:0] f_up_q;

  // Stage G: products on the square term
  logic             g_vld_q, g_ft_q;
  logic [WordW-1:0] g_m1_q, g_m2_q, g_x2a_q, g_x1c_q;
  logic [TempW-1:0] g_t_q;
  logic [RawPresW-1:0] g_up_q;

  logic [WordW-1:0] g_sq_d;
  assign g_sq_d = WordW'($signed(f_sq_q) >>> 12);

  // Stage H: B3 and the B4 term
  logic             h_vld_q, h_ft_q;
  logic [WordW-1:0] h_b3_q, h_x3_q;
  logic [TempW-1:0] h_t_q;
  logic [RawPresW-1:0] h_up_q;

  logic [WordW-1:0] h_x3a_d, h_b3p_d, h_x3b_d;
  assign h_x3a_d = WordW'($signed(g_m1_q) >>> 11) + g_x2a_q;
  assign h_b3p_d = (((ac1 << 2) + h_x3a_d) << oss_q) + 32'd2;
  assign h_x3b_d = WordW'($signed(g_m2_q) >>> 16) + g_x1c_q + 32'd2;

  // Stage I: B4 product and UP - B3
  logic             i_vld_q, i_ft_q;
  logic [WordW-1:0] i_b4p_q, i_b7p_q;
  logic [TempW-1:0] i_t_q;

  // Stage J: B4 and B7
  logic             j_vld_q, j_ft_q;
  logic [WordW-1:0] j_b4_q, j_b7_q;
  logic [TempW-1:0] j_t_q;

  logic [WordW-1:0] j_b4_d;
  assign j_b4_d = i_b4p_q >> 15;

  // Pressure divider: B7 * 2 / B4, or B7 / B4 then doubled when B7 is large
  localparam int unsigned PSideW = TempW + 2;
  logic              pd_big;
  logic [WordW-1:0]  pd_num;
  logic              pd_vld;
  logic [WordW-1:0]  pd_quo;
  logic [PSideW-1:0] pd_side;

  assign pd_big = j_b7_q[WordW-1];
  assign pd_num = pd_big ? j_b7_q : (j_b7_q << 1);

  bpc_div_pipe #(
    .W  (WordW),
    .SW (PSideW)
  ) u_div_pres (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (j_vld_q),
    .num_i  (pd_num),
    .den_i  (j_b4_q),
    .side_i ({j_t_q, j_ft_q, pd_big}),
    .vld_o  (pd_vld),
    .quo_o  (pd_quo),
    .side_o (pd_side)
  );

  // Stage L: P
  logic             l_vld_q, l_ft_q;
  logic [WordW-1:0] l_p_q;
  logic [TempW-1:0] l_t_q;

  // Stage M: (P >> 8)^2 and the linear term
  logic             m_vld_q, m_ft_q;
  logic [WordW-1:0] m_p_q, m_sq_q, m_lin_q;
  logic [TempW-1:0] m_t_q;

  logic [WordW-1:0] m_ps_d;
  assign m_ps_d = WordW'($signed(l_p_q) >>> 8);

  // Stage N: square term scaled
  logic             n_vld_q, n_ft_q;
  logic [WordW-1:0] n_p_q, n_x1_q, n_x2_q;
  logic [TempW-1:0] n_t_q;

  // Output stage
  logic [TempW-1:0] out_t_q;
  logic [PresW-1:0] out_p_q;
  logic             out_ft_q;

  logic signed [WordW-1:0] o_prs_d;
  logic [PresW-1:0]        o_psat_d;
  assign o_prs_d = $signed(n_p_q + WordW'($signed(n_x1_q + n_x2_q + PresOffset) >>> 4));
  always_comb begin
    if (o_prs_d < 0) begin
      o_psat_d = '0;
    end else if (o_prs_d > PresMax) begin
      o_psat_d = PresMax[PresW-1:0];
    end else begin
      o_psat_d = o_prs_d[PresW-1:0];
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      b_vld_q   <= 1'b0;
      c_vld_q   <= 1'b0;
      d_vld_q   <= 1'b0;
      e_vld_q   <= 1'b0;
      f_vld_q   <= 1'b0;
      g_vld_q   <= 1'b0;
      h_vld_q   <= 1'b0;
      i_vld_q   <= 1'b0;
      j_vld_q   <= 1'b0;
      l_vld_q   <= 1'b0;
      m_vld_q   <= 1'b0;
      n_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q   <= s_axis_tvalid;
      b_vld_q   <= a_vld_q;
      c_vld_q   <= td_vld;
      d_vld_q   <= c_vld_q;
      e_vld_q   <= d_vld_q;
      f_vld_q   <= e_vld_q;
      g_vld_q   <= f_vld_q;
      h_vld_q   <= g_vld_q;
      i_vld_q   <= h_vld_q;
      j_vld_q   <= i_vld_q;
      l_vld_q   <= pd_vld;
      m_vld_q   <= l_vld_q;
      n_vld_q   <= m_vld_q;
      out_vld_q <= n_vld_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (en) begin
      // A
      a_prod_q <= (ut - ac6) * ac5;
      a_up_q   <= s_axis_tdata[RawTempW +: RawPresW];
      // B: magnitudes for the unsigned divider, sign applied afterwards
      b_x1_q  <= b_x1_d;
      b_num_q <= b_mcs_d[WordW-1] ? (32'd0 - b_mcs_d) : b_mcs_d;
      b_den_q <= b_tmp_d[WordW-1] ? (32'd0 - b_tmp_d) : b_tmp_d;
      b_neg_q <= b_mcs_d[WordW-1] ^ b_tmp_d[WordW-1];
      b_ft_q  <= (b_tmp_d == '0);
      b_up_q  <= a_up_q;
      // C
      c_x1_q <= td_side[TSideW-1 -: WordW];
      c_x2_q <= td_side[RawPresW+1] ? (32'd0 - td_quo) : td_quo;
      c_ft_q <= td_side[RawPresW];
      c_up_q <= td_side[RawPresW-1:0];
      // D
      d_b5_q <= c_x1_q + c_x2_q;
      d_ft_q <= c_ft_q;
      d_up_q <= c_up_q;
      // E
      e_b6_q <= d_b5_q - TempOffset;
      e_t_q  <= e_tsat_d;
      e_ft_q <= d_ft_q;
      e_up_q <= d_up_q;
      // F
      f_sq_q  <= e_b6_q * e_b6_q;
      f_ac2_q <= ac2 * e_b6_q;
      f_ac3_q <= ac3 * e_b6_q;
      f_t_q   <= e_t_q;
      f_ft_q  <= e_ft_q;
      f_up_q  <= e_up_q;
      // G
      g_m1_q  <= b2 * g_sq_d;
      g_m2_q  <= b1 * g_sq_d;
      g_x2a_q <= WordW'($signed(f_ac2_q) >>> 11);
      g_x1c_q <= WordW'($signed(f_ac3_q) >>> 13);
      g_t_q   <= f_t_q;
      g_ft_q  <= f_ft_q;
      g_up_q  <= f_up_q;
      // H
      h_b3_q <= WordW'($signed(h_b3p_d) >>> 2);
      h_x3_q <= WordW'($signed(h_x3b_d) >>> 2);
      h_t_q  <= g_t_q;
      h_ft_q <= g_ft_q;
      h_up_q <= g_up_q;
      // I
      i_b4p_q <= ac4 * (h_x3_q + B4Bias);
      i_b7p_q <= {13'd0, h_up_q} - h_b3_q;
      i_t_q   <= h_t_q;
      i_ft_q  <= h_ft_q;
      // J
      j_b4_q <= j_b4_d;
      j_b7_q <= i_b7p_q * (B7Scale >> oss_q);
      j_t_q  <= i_t_q;
      j_ft_q <= i_ft_q || (j_b4_d == '0);
      // L
      l_p_q  <= pd_side[0] ? (pd_quo << 1) : pd_quo;
      l_ft_q <= pd_side[1];
      l_t_q  <= pd_side[PSideW-1 -: TempW];
      // M
      m_p_q   <= l_p_q;
      m_sq_q  <= m_ps_d * m_ps_d;
      m_lin_q <= PresCoefLin * l_p_q;
      m_t_q   <= l_t_q;
      m_ft_q  <= l_ft_q;
      // N
      n_p_q  <= m_p_q;
      n_x1_q <= WordW'($signed(m_sq_q * PresCoefSq) >>> 16);
      n_x2_q <= WordW'($signed(m_lin_q) >>> 16);
      n_t_q  <= m_t_q;
      n_ft_q <= m_ft_q;
      // Output: zero both results on a divide fault
      out_t_q  <= n_ft_q ? '0 : n_t_q;
      out_p_q  <= n_ft_q ? '0 : o_psat_d;
      out_ft_q <= n_ft_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'd0, out_p_q, out_t_q};
  assign m_axis_tuser  = out_ft_q;

endmodule
